// File: hdl/per_thread_tagged_message_parser_unit_assert.svh
// assertion macros shared by the parser rtl
`ifndef PER_THREAD_TAGGED_MESSAGE_PARSER_UNIT_ASSERT_SVH
`define PER_THREAD_TAGGED_MESSAGE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTMP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptmp assertion failed");

// next-cycle implication
`define PTMP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptmp assertion failed");

`endif

// File: hdl/ptmp_pkg.sv
package ptmp_pkg;

   // parse modes
   localparam logic [4:0] MODE_IDLE  = 5'd0;
   localparam logic [4:0] MODE_OUT   = 5'd1;
   localparam logic [4:0] MODE_ERR   = 5'd2;
   localparam logic [4:0] MODE_EXIT  = 5'd3;
   localparam logic [4:0] MODE_PERF0 = 5'd4;
   localparam logic [4:0] MODE_PERF7 = 5'd11;
   localparam logic [4:0] MODE_DEV   = 5'd12;
   localparam logic [4:0] MODE_KEY   = 5'd13;
   localparam logic [4:0] MODE_VAL   = 5'd14;
   localparam logic [4:0] MODE_AFILE = 5'd15;
   localparam logic [4:0] MODE_ALINE = 5'd16;

   // tag bytes
   localparam logic [7:0] TAG_STDOUT = 8'h01;
   localparam logic [7:0] TAG_STDERR = 8'h02;
   localparam logic [7:0] TAG_AFILE  = 8'hFD;
   localparam logic [7:0] TAG_ASSERT = 8'hFE;
   localparam logic [7:0] TAG_EXIT   = 8'hFF;
   localparam logic [7:0] TAG_PERF   = 8'h20;
   localparam logic [7:0] TAG_KEYVAL = 8'h10;

   // event kinds
   localparam logic [3:0] EV_STDOUT  = 4'd0;
   localparam logic [3:0] EV_STDERR  = 4'd1;
   localparam logic [3:0] EV_AFILE   = 4'd2;
   localparam logic [3:0] EV_ALINE   = 4'd3;
   localparam logic [3:0] EV_ASSERT  = 4'd4;
   localparam logic [3:0] EV_EXIT    = 4'd5;
   localparam logic [3:0] EV_PERF    = 4'd6;
   localparam logic [3:0] EV_DEVCHAR = 4'd7;
   localparam logic [3:0] EV_KEY     = 4'd8;
   localparam logic [3:0] EV_VALUE   = 4'd9;
   localparam logic [3:0] EV_BADTAG  = 4'd10;

   // perfmon counter numbers that the check handles specially
   localparam logic [2:0] PERF_THREAD   = 3'd0;
   localparam logic [2:0] PERF_SEND     = 3'd4;
   localparam logic [2:0] PERF_SEND_HDL = 3'd5;
   localparam logic [2:0] PERF_RECV     = 3'd6;
   localparam logic [2:0] PERF_RECV_HDL = 3'd7;

   localparam logic [1:0] LAST_BYTE_OF_WORD = 2'd3;

   // per-thread parse context, one memory word
   typedef struct packed {
      logic [4:0]  mode;
      logic [1:0]  count;
      logic [31:0] acc;
      logic [31:0] total;
      logic [31:0] send;
      logic [31:0] recv;
      logic        check;
   } ctx_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [9:0]  source_thread;
      logic [31:0] payload;
      logic [2:0]  word_index;
      logic        last;
      logic        sanity_failed;
      logic        fatal;
   } event_type;

endpackage

// File: hdl/ptmp_ctx_mem.sv
module ptmp_ctx_mem #(
   parameter int THREADS = 1024,
   localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ptmp_pkg::ctx_type    wr_data,
   output ptmp_pkg::ctx_type    rd_data,
   output logic                 clear_busy
);

   ptmp_pkg::ctx_type ctx_ram [THREADS];

   ptmp_pkg::ctx_type rd_q_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              byp_valid_ff, byp_valid_in;
   logic [AW-1:0]     byp_addr_ff;
   ptmp_pkg::ctx_type byp_data_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   ptmp_pkg::ctx_type ram_wdata;

   // clearing sweep owns the write port after reset
   assign ram_we    = clr_busy_ff | wr_en;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign ram_wdata = clr_busy_ff ? '0 : wr_data;

   always_comb begin
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      byp_valid_in = byp_valid_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(THREADS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end else if (wr_en) begin
         byp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ctx_ram[ram_waddr] <= ram_wdata;
      end
      if (rd_en) begin
         rd_q_ff    <= ctx_ram[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en && !clr_busy_ff) begin
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
   end

   // a write in the read's own cycle is not yet in the registered read data
   assign rd_data = (byp_valid_ff && byp_addr_ff == rd_addr_ff) ? byp_data_ff : rd_q_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// File: hdl/per_thread_tagged_message_parser_unit.sv
// throughput: one beat per cycle, any mix of threads, while the result channel does not stall;
//   the context memory read-modify-write uses a write bypass for back-to-back beats of
//   the same thread
// reset: synchronous; afterwards a clearing pass sets every context to idle
//   while req_tready stays low; the halt flag clears at reset
`include "per_thread_tagged_message_parser_unit_assert.svh"

module per_thread_tagged_message_parser_unit #(
   parameter int THREADS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // thread_id[9:0], data_byte[17:10], zero pad
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // source_thread[9:0], payload[41:10], word_index[44:42],
                                    // sanity_failed[45], fatal[46], zero pad
   output logic [3:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast    // last
);

   localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;

   // ------------------------------------------------------------------
   // stage one: the beat whose context is being read
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [9:0]  s1_thread_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_inrange_ff;
   logic        halted_ff, halted_in;

   logic        req_fire;
   logic        out_free;
   logic        s1_adv;
   logic        s1_act;
   logic        clear_busy;
   logic [9:0]  req_thread;
   logic [7:0]  req_byte;
   logic        req_inrange;

   ptmp_pkg::ctx_type   ctx_rd;
   ptmp_pkg::ctx_type   ctx_nxt;
   ptmp_pkg::event_type ev;
   logic                ev_valid;

   ptmp_pkg::event_type rsp_ev_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_thread  = req_tdata[9:0];
   assign req_byte    = req_tdata[17:10];
   assign req_inrange = (32'(req_thread) < THREADS);

   // output register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !clear_busy && (!s1_valid_ff || out_free);
   assign req_fire   = req_tvalid && req_tready;
   // bytes after a halt or for a missing thread change nothing
   assign s1_act     = s1_valid_ff && s1_inrange_ff && !halted_ff;

   ptmp_ctx_mem #(
      .THREADS (THREADS)
   ) u_ctx_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_addr    (AW'(req_thread)),
      .wr_en      (s1_adv && s1_act),
      .wr_addr    (AW'(s1_thread_ff)),
      .wr_data    (ctx_nxt),
      .rd_data    (ctx_rd),
      .clear_busy (clear_busy)
   );

   // ------------------------------------------------------------------
   // per-byte parse step
   // ------------------------------------------------------------------
   always_comb begin
      logic [31:0] acc_sh;
      logic        wdone;
      logic [1:0]  cnt_inc;
      logic [4:0]  k_wide;
      logic [2:0]  k;
      logic [31:0] cmp_ref;
      logic        cmp_gt;
      logic        is_perf;
      logic        zb;
      logic        chk;

      acc_sh  = {s1_byte_ff, ctx_rd.acc[31:8]};
      wdone   = (ctx_rd.count == ptmp_pkg::LAST_BYTE_OF_WORD);
      cnt_inc = wdone ? 2'd0 : ctx_rd.count + 2'd1;
      k_wide  = ctx_rd.mode - ptmp_pkg::MODE_PERF0;
      k       = k_wide[2:0];
      zb      = (s1_byte_ff == 8'd0);
      is_perf = (ctx_rd.mode >= ptmp_pkg::MODE_PERF0) && (ctx_rd.mode <= ptmp_pkg::MODE_PERF7);

      // handler words compare with their own counter, the rest with the thread word
      priority if (k == ptmp_pkg::PERF_SEND_HDL) begin
         cmp_ref = ctx_rd.send;
      end else if (k == ptmp_pkg::PERF_RECV_HDL) begin
         cmp_ref = ctx_rd.recv;
      end else begin
         cmp_ref = ctx_rd.total;
      end
      cmp_gt = (acc_sh > cmp_ref);

      ctx_nxt  = ctx_rd;
      ev       = '0;
      ev.source_thread = s1_thread_ff;
      ev_valid = 1'b0;
      chk      = ctx_rd.check;

      if (is_perf) begin
         ctx_nxt.acc   = acc_sh;
         ctx_nxt.count = cnt_inc;
         if (wdone) begin
            if (k == ptmp_pkg::PERF_THREAD) begin
               ctx_nxt.total = acc_sh;
               chk = 1'b0;
            end else begin
               chk = ctx_rd.check | cmp_gt;
            end
            if (k == ptmp_pkg::PERF_SEND) begin
               ctx_nxt.send = acc_sh;
            end
            if (k == ptmp_pkg::PERF_RECV) begin
               ctx_nxt.recv = acc_sh;
            end
            ctx_nxt.check = chk;
            ev_valid      = 1'b1;
            ev.event_kind = ptmp_pkg::EV_PERF;
            ev.payload    = acc_sh;
            ev.word_index = k;
            if (k == ptmp_pkg::PERF_RECV_HDL) begin
               ctx_nxt.mode     = ptmp_pkg::MODE_IDLE;
               ev.last          = 1'b1;
               ev.sanity_failed = chk;
            end else begin
               ctx_nxt.mode = ctx_rd.mode + 5'd1;
            end
         end
      end else begin
         unique case (ctx_rd.mode)
            ptmp_pkg::MODE_OUT, ptmp_pkg::MODE_ERR: begin
               if (zb) begin
                  ctx_nxt.mode = ptmp_pkg::MODE_IDLE;
               end
               ev_valid      = 1'b1;
               ev.event_kind = (ctx_rd.mode == ptmp_pkg::MODE_OUT) ?
                               ptmp_pkg::EV_STDOUT : ptmp_pkg::EV_STDERR;
               ev.payload    = 32'(s1_byte_ff);
               ev.last       = zb;
            end
            ptmp_pkg::MODE_AFILE, ptmp_pkg::MODE_DEV: begin
               if (zb) begin
                  ctx_nxt.mode  = (ctx_rd.mode == ptmp_pkg::MODE_AFILE) ?
                                  ptmp_pkg::MODE_ALINE : ptmp_pkg::MODE_KEY;
                  ctx_nxt.count = 2'd0;
               end
               ev_valid      = 1'b1;
               ev.event_kind = (ctx_rd.mode == ptmp_pkg::MODE_AFILE) ?
                               ptmp_pkg::EV_AFILE : ptmp_pkg::EV_DEVCHAR;
               ev.payload    = 32'(s1_byte_ff);
               ev.last       = zb;
            end
            ptmp_pkg::MODE_ALINE, ptmp_pkg::MODE_EXIT: begin
               ctx_nxt.acc   = acc_sh;
               ctx_nxt.count = cnt_inc;
               ev_valid      = wdone;
               ev.event_kind = (ctx_rd.mode == ptmp_pkg::MODE_ALINE) ?
                               ptmp_pkg::EV_ALINE : ptmp_pkg::EV_EXIT;
               ev.payload    = acc_sh;
               ev.fatal      = 1'b1;
            end
            ptmp_pkg::MODE_KEY, ptmp_pkg::MODE_VAL: begin
               ctx_nxt.acc   = acc_sh;
               ctx_nxt.count = cnt_inc;
               if (wdone) begin
                  ctx_nxt.mode = (ctx_rd.mode == ptmp_pkg::MODE_KEY) ?
                                 ptmp_pkg::MODE_VAL : ptmp_pkg::MODE_IDLE;
               end
               ev_valid      = wdone;
               ev.event_kind = (ctx_rd.mode == ptmp_pkg::MODE_KEY) ?
                               ptmp_pkg::EV_KEY : ptmp_pkg::EV_VALUE;
               ev.payload    = acc_sh;
            end
            default: begin
               // idle: a tag byte opens a message or raises an assert or bad-tag event
               unique case (s1_byte_ff)
                  ptmp_pkg::TAG_STDOUT: ctx_nxt.mode = ptmp_pkg::MODE_OUT;
                  ptmp_pkg::TAG_STDERR: ctx_nxt.mode = ptmp_pkg::MODE_ERR;
                  ptmp_pkg::TAG_AFILE:  ctx_nxt.mode = ptmp_pkg::MODE_AFILE;
                  ptmp_pkg::TAG_KEYVAL: ctx_nxt.mode = ptmp_pkg::MODE_DEV;
                  ptmp_pkg::TAG_EXIT: begin
                     ctx_nxt.mode  = ptmp_pkg::MODE_EXIT;
                     ctx_nxt.count = 2'd0;
                  end
                  ptmp_pkg::TAG_PERF: begin
                     ctx_nxt.mode  = ptmp_pkg::MODE_PERF0;
                     ctx_nxt.count = 2'd0;
                  end
                  ptmp_pkg::TAG_ASSERT: begin
                     ev_valid      = 1'b1;
                     ev.event_kind = ptmp_pkg::EV_ASSERT;
                     ev.fatal      = 1'b1;
                  end
                  default: begin
                     ev_valid      = 1'b1;
                     ev.event_kind = ptmp_pkg::EV_BADTAG;
                     ev.payload    = 32'(s1_byte_ff);
                     ev.fatal      = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_adv && s1_act && ev_valid) ? 1'b1 :
                     (rsp_tready ? 1'b0 : rsp_valid_ff);
      halted_in    = halted_ff | (s1_adv && s1_act && ev_valid && ev.fatal);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         halted_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         halted_ff    <= halted_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_thread_ff  <= req_thread;
         s1_byte_ff    <= req_byte;
         s1_inrange_ff <= req_inrange;
      end
      if (s1_adv && s1_act && ev_valid) begin
         rsp_ev_ff <= ev;
      end
   end

   // ------------------------------------------------------------------
   // result channel
   // ------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff.event_kind;
   assign rsp_tlast  = rsp_ev_ff.last;
   assign rsp_tdata  = {1'b0, rsp_ev_ff.fatal, rsp_ev_ff.sanity_failed, rsp_ev_ff.word_index,
                        rsp_ev_ff.payload, rsp_ev_ff.source_thread};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `PTMP_ASSERT_NOW(a_no_beat_while_clearing, clock, reset, req_tready, !clear_busy)
   `PTMP_ASSERT_NEXT(a_halt_is_sticky, clock, reset, halted_ff, halted_ff)
   `PTMP_ASSERT_NOW(a_fatal_beat_halts, clock, reset, rsp_valid_ff && rsp_ev_ff.fatal, halted_ff)
   `PTMP_ASSERT_NOW(a_halted_stays_quiet, clock, reset, halted_ff, !(s1_act && ev_valid))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int SLOTS = 6;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;      // thread_id[9:0], data_byte[17:10], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // source_thread, payload, word_index, sanity_failed, fatal
   logic [3:0]  rsp_tuser;           // event_kind
   logic        rsp_tlast;           // last

   per_thread_tagged_message_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned long_hold_request = 0;

   // mirror of the per-thread parse contexts
   logic [4:0]  ctx_mode  [1024];
   logic [1:0]  ctx_count [1024];
   logic [31:0] ctx_acc   [1024];
   logic [31:0] ctx_total [1024];
   logic [31:0] ctx_send  [1024];
   logic [31:0] ctx_recv  [1024];
   logic        ctx_check [1024];
   logic        block_halted;

   ptmp_pkg::event_type expected_events [$];

   // traffic slots, each owns one thread with a partly sent message
   logic [9:0]  slot_thread [SLOTS];
   logic [7:0]  slot_bytes  [SLOTS][$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void note_event(input logic [3:0] kind, input logic [9:0] tid,
                                      input logic [31:0] payload, input logic [2:0] idx,
                                      input logic last, input logic bad, input logic fatal);
      ptmp_pkg::event_type ev;
      ev.event_kind    = kind;
      ev.source_thread = tid;
      ev.payload       = payload;
      ev.word_index    = idx;
      ev.last          = last;
      ev.sanity_failed = bad;
      ev.fatal         = fatal;
      expected_events.insert(expected_events.size(), ev);
      if (fatal) block_halted = 1'b1;
   endfunction

   // shift a byte in from the top, true once the word is complete
   function automatic logic shift_in(input logic [9:0] tid, input logic [7:0] b);
      ctx_acc[tid] = {b, ctx_acc[tid][31:8]};
      if (ctx_count[tid] == ptmp_pkg::LAST_BYTE_OF_WORD) begin
         ctx_count[tid] = 2'd0;
         return 1'b1;
      end
      ctx_count[tid] = ctx_count[tid] + 2'd1;
      return 1'b0;
   endfunction

   task automatic parse_byte(input logic [9:0] tid, input logic [7:0] b);
      logic [4:0]  m;
      logic [2:0]  k;
      logic [31:0] w;
      logic        z;
      if (block_halted) return;
      m = ctx_mode[tid];
      z = (b == 8'h00);
      if (m >= ptmp_pkg::MODE_PERF0 && m <= ptmp_pkg::MODE_PERF7) begin
         k = 3'(m - ptmp_pkg::MODE_PERF0);
         if (!shift_in(tid, b)) return;
         w = ctx_acc[tid];
         case (k)
            ptmp_pkg::PERF_THREAD: begin
               ctx_total[tid] = w;
               ctx_check[tid] = 1'b0;
            end
            ptmp_pkg::PERF_SEND_HDL: if (w > ctx_send[tid]) ctx_check[tid] = 1'b1;
            ptmp_pkg::PERF_RECV_HDL: if (w > ctx_recv[tid]) ctx_check[tid] = 1'b1;
            default: begin
               if (ctx_total[tid] < w) ctx_check[tid] = 1'b1;
               if (k == ptmp_pkg::PERF_SEND) ctx_send[tid] = w;
               if (k == ptmp_pkg::PERF_RECV) ctx_recv[tid] = w;
            end
         endcase
         if (k == ptmp_pkg::PERF_RECV_HDL) begin
            ctx_mode[tid] = ptmp_pkg::MODE_IDLE;
            note_event(ptmp_pkg::EV_PERF, tid, w, k, 1'b1, ctx_check[tid], 1'b0);
         end else begin
            ctx_mode[tid] = m + 5'd1;
            note_event(ptmp_pkg::EV_PERF, tid, w, k, 1'b0, 1'b0, 1'b0);
         end
         return;
      end
      case (m)
         ptmp_pkg::MODE_OUT: begin
            if (z) ctx_mode[tid] = ptmp_pkg::MODE_IDLE;
            note_event(ptmp_pkg::EV_STDOUT, tid, 32'(b), 3'd0, z, 1'b0, 1'b0);
         end
         ptmp_pkg::MODE_ERR: begin
            if (z) ctx_mode[tid] = ptmp_pkg::MODE_IDLE;
            note_event(ptmp_pkg::EV_STDERR, tid, 32'(b), 3'd0, z, 1'b0, 1'b0);
         end
         ptmp_pkg::MODE_AFILE: begin
            if (z) begin
               ctx_mode[tid]  = ptmp_pkg::MODE_ALINE;
               ctx_count[tid] = 2'd0;
            end
            note_event(ptmp_pkg::EV_AFILE, tid, 32'(b), 3'd0, z, 1'b0, 1'b0);
         end
         ptmp_pkg::MODE_ALINE:
            if (shift_in(tid, b))
               note_event(ptmp_pkg::EV_ALINE, tid, ctx_acc[tid], 3'd0, 1'b0, 1'b0, 1'b1);
         ptmp_pkg::MODE_EXIT:
            if (shift_in(tid, b))
               note_event(ptmp_pkg::EV_EXIT, tid, ctx_acc[tid], 3'd0, 1'b0, 1'b0, 1'b1);
         ptmp_pkg::MODE_DEV: begin
            if (z) begin
               ctx_mode[tid]  = ptmp_pkg::MODE_KEY;
               ctx_count[tid] = 2'd0;
            end
            note_event(ptmp_pkg::EV_DEVCHAR, tid, 32'(b), 3'd0, z, 1'b0, 1'b0);
         end
         ptmp_pkg::MODE_KEY:
            if (shift_in(tid, b)) begin
               ctx_mode[tid] = ptmp_pkg::MODE_VAL;
               note_event(ptmp_pkg::EV_KEY, tid, ctx_acc[tid], 3'd0, 1'b0, 1'b0, 1'b0);
            end
         ptmp_pkg::MODE_VAL:
            if (shift_in(tid, b)) begin
               ctx_mode[tid] = ptmp_pkg::MODE_IDLE;
               note_event(ptmp_pkg::EV_VALUE, tid, ctx_acc[tid], 3'd0, 1'b0, 1'b0, 1'b0);
            end
         default:
            case (b)
               ptmp_pkg::TAG_STDOUT: ctx_mode[tid] = ptmp_pkg::MODE_OUT;
               ptmp_pkg::TAG_STDERR: ctx_mode[tid] = ptmp_pkg::MODE_ERR;
               ptmp_pkg::TAG_AFILE:  ctx_mode[tid] = ptmp_pkg::MODE_AFILE;
               ptmp_pkg::TAG_ASSERT:
                  note_event(ptmp_pkg::EV_ASSERT, tid, 32'd0, 3'd0, 1'b0, 1'b0, 1'b1);
               ptmp_pkg::TAG_EXIT: begin
                  ctx_mode[tid]  = ptmp_pkg::MODE_EXIT;
                  ctx_count[tid] = 2'd0;
               end
               ptmp_pkg::TAG_PERF: begin
                  ctx_mode[tid]  = ptmp_pkg::MODE_PERF0;
                  ctx_count[tid] = 2'd0;
               end
               ptmp_pkg::TAG_KEYVAL: ctx_mode[tid] = ptmp_pkg::MODE_DEV;
               default:
                  note_event(ptmp_pkg::EV_BADTAG, tid, 32'(b), 3'd0, 1'b0, 1'b0, 1'b1);
            endcase
      endcase
   endtask

   // ---------------------------------------------------------------- drivers

   // one beat on the request side, with random idle cycles ahead of it
   task automatic send_byte(input logic [9:0] tid, input logic [7:0] b);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, b, tid};
      do @(posedge clock); while (req_tready !== 1'b1);
      parse_byte(tid, b);
   endtask

   // result sink: random stalls, plus a long hold-off when one is requested
   initial begin : rsp_sink
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_request != 0) begin
            hold_left = long_hold_request;
            long_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      ptmp_pkg::event_type got;
      ptmp_pkg::event_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.event_kind    = rsp_tuser;
         got.source_thread = rsp_tdata[9:0];
         got.payload       = rsp_tdata[41:10];
         got.word_index    = rsp_tdata[44:42];
         got.last          = rsp_tlast;
         got.sanity_failed = rsp_tdata[45];
         got.fatal         = rsp_tdata[46];
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual kind %0d thread %0d payload %h",
                     $time, got.event_kind, got.source_thread, got.payload);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            check_field("source_thread", 32'(want.source_thread), 32'(got.source_thread));
            check_field("payload", want.payload, got.payload);
            check_field("word_index", 32'(want.word_index), 32'(got.word_index));
            check_field("last", 32'(want.last), 32'(got.last));
            check_field("sanity_failed", 32'(want.sanity_failed), 32'(got.sanity_failed));
            check_field("fatal", 32'(want.fatal), 32'(got.fatal));
         end
      end
   end

   // ---------------------------------------------------------------- message builders

   function automatic logic [9:0] free_thread();
      logic [9:0] t;
      logic       clash;
      do begin
         t = 10'($urandom_range(1023));
         clash = 1'b0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_thread[i] == t) clash = 1'b1;
      end while (clash);
      return t;
   endfunction

   // adds one byte at the tail of a slot's pending bytes
   task automatic append_byte(input int s, input logic [7:0] b);
      slot_bytes[s].insert(slot_bytes[s].size(), b);
   endtask

   // words go out least significant byte first
   task automatic push_word(input int s, input logic [31:0] w);
      for (int i = 0; i < 4; i++) append_byte(s, w[8*i +: 8]);
   endtask

   // tag, non-zero characters, terminating zero
   task automatic queue_text(input int s, input logic [7:0] tag, input int max_len);
      int n;
      n = $urandom_range(max_len);
      append_byte(s, tag);
      repeat (n) append_byte(s, 8'($urandom_range(255, 1)));
      append_byte(s, 8'h00);
   endtask

   // eight counters, mostly consistent, some with one counter out of bounds
   task automatic queue_perfmon(input int s);
      logic [31:0] w [8];
      int          j;
      w[0] = ($urandom_range(7) == 0) ? 32'($urandom_range(3)) : $urandom;
      for (int i = 1; i < 8; i++) begin
         if (i == 5 || i == 7)
            w[i] = ($urandom_range(3) == 0) ? w[i-1] : $urandom_range(w[i-1], 0);
         else
            w[i] = ($urandom_range(3) == 0) ? w[0] : $urandom_range(w[0], 0);
      end
      if ($urandom_range(1) == 0) begin
         j = $urandom_range(7, 1);
         if ($urandom_range(1) == 0)
            w[j] = $urandom;
         else
            w[j] = ((j == 5) ? w[4] : (j == 7) ? w[6] : w[0]) + 32'd1;  // just over the bound
      end
      append_byte(s, ptmp_pkg::TAG_PERF);
      for (int i = 0; i < 8; i++) push_word(s, w[i]);
   endtask

   task automatic queue_message(input int s);
      case ($urandom_range(9))
         0, 1, 2: queue_text(s, ptmp_pkg::TAG_STDOUT, 12);
         3:       queue_text(s, ptmp_pkg::TAG_STDERR, 12);
         4, 5, 6: queue_perfmon(s);
         default: begin
            queue_text(s, ptmp_pkg::TAG_KEYVAL, 8);
            push_word(s, $urandom);
            push_word(s, $urandom);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_messages();
      // stdout on thread 0 with both byte extremes
      send_byte(10'd0, ptmp_pkg::TAG_STDOUT);
      send_byte(10'd0, 8'h48);
      send_byte(10'd0, 8'hFF);
      send_byte(10'd0, 8'h00);
      // empty stderr text on the top thread
      send_byte(10'd1023, ptmp_pkg::TAG_STDERR);
      send_byte(10'd1023, 8'h00);
      // key/value record, device name interleaved with a text holding tag values
      send_byte(10'h2AA, ptmp_pkg::TAG_KEYVAL);
      send_byte(10'h155, ptmp_pkg::TAG_STDOUT);
      send_byte(10'h2AA, 8'h7F);
      send_byte(10'h155, ptmp_pkg::TAG_STDOUT);
      send_byte(10'h2AA, 8'h00);
      send_byte(10'h155, ptmp_pkg::TAG_ASSERT);
      send_byte(10'h2AA, 8'h00);
      send_byte(10'h155, ptmp_pkg::TAG_PERF);
      send_byte(10'h2AA, 8'h00);
      send_byte(10'h155, 8'h00);
      send_byte(10'h2AA, 8'h00);
      send_byte(10'h2AA, 8'h80);
      // value word all ones, its event carries no last flag
      repeat (4) send_byte(10'h2AA, 8'hFF);
   endtask

   // well-formed messages on several threads, bytes interleaved between them
   task automatic test_random_mixed(input int n_items);
      int s;
      s = 0;
      repeat (n_items) begin
         if ($urandom_range(9) > 2) s = $urandom_range(SLOTS - 1);
         if (slot_bytes[s].size() == 0) begin
            if ($urandom_range(3) == 0) slot_thread[s] = free_thread();
            queue_message(s);
         end
         send_byte(slot_thread[s], slot_bytes[s].pop_front());
      end
   endtask

   // sink holds off for a long stretch while beats keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      long_hold_request = 300;
      test_random_mixed(80);
   endtask

   // finish open messages, then one halting message and some bytes that must be dropped
   task automatic test_fatal_halt();
      logic [7:0] b;
      for (int s = 0; s < SLOTS; s++)
         while (slot_bytes[s].size() != 0) send_byte(slot_thread[s], slot_bytes[s].pop_front());
      slot_thread[0] = free_thread();
      case ($urandom_range(3))
         0: append_byte(0, ptmp_pkg::TAG_ASSERT);
         1: begin
            append_byte(0, ptmp_pkg::TAG_EXIT);
            push_word(0, $urandom);
         end
         2: begin
            queue_text(0, ptmp_pkg::TAG_AFILE, 10);
            push_word(0, $urandom);
         end
         default: begin
            do b = 8'($urandom);
            while (b inside {ptmp_pkg::TAG_STDOUT, ptmp_pkg::TAG_STDERR, ptmp_pkg::TAG_AFILE,
                             ptmp_pkg::TAG_ASSERT, ptmp_pkg::TAG_EXIT, ptmp_pkg::TAG_PERF,
                             ptmp_pkg::TAG_KEYVAL});
            append_byte(0, b);
         end
      endcase
      while (slot_bytes[0].size() != 0) send_byte(slot_thread[0], slot_bytes[0].pop_front());
      // halted: these are accepted and produce nothing
      repeat (12) send_byte(10'($urandom), 8'($urandom));
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main
      for (int i = 0; i < 1024; i++) begin
         ctx_mode[i]  = ptmp_pkg::MODE_IDLE;
         ctx_count[i] = '0;
         ctx_acc[i]   = '0;
         ctx_total[i] = '0;
         ctx_send[i]  = '0;
         ctx_recv[i]  = '0;
         ctx_check[i] = 1'b0;
      end
      block_halted = 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_thread[i] = 10'd0;
      slot_thread[1] = 10'd1023;
      for (int i = 2; i < SLOTS; i++) slot_thread[i] = free_thread();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      rsp_stall_pct = 80;
      test_directed_messages();
      test_random_mixed(480);

      send_idle_pct = 80;
      rsp_stall_pct = 24;
      test_random_mixed(480);

      test_backpressure();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_mixed(420);
      test_fatal_halt();

      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
